// File: rtl/hop_channel_resync_tracker_unit_defines.svh
// Assertion macros shared by the checker files of the hop tracker.
// Depends on nothing; expects signals named clock and reset in scope.
`ifndef HOP_CHANNEL_RESYNC_TRACKER_UNIT_DEFINES_SVH
`define HOP_CHANNEL_RESYNC_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HCRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HCRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hcrt_pkg.sv
// Shared types and constants of the hop channel resync tracker.
// No dependencies; used by the top level and its checker.
package hcrt_pkg;

   // Default channel count of the hop sequence
   localparam int CHANNEL_COUNT_DEF = 16;

   // Widths of the fixed fields
   localparam int TIME_W   = 32;
   localparam int DWELL_W  = 16;
   localparam int OFFSET_W = 6;
   localparam int CHAN_W   = 6;
   localparam int MISS_W   = 3;
   localparam int CSR_W    = 16;

   // Miss count at which forward hopping stops and backward resync starts
   localparam logic [MISS_W-1:0] FWD_MISS_LIMIT = 3'd6;

   // Register reset values
   localparam logic [OFFSET_W-1:0] HOP_OFFSET_RST  = 6'd1;
   localparam logic [DWELL_W-1:0]  DWELL_MS_RST    = 16'd20;
   localparam logic [DWELL_W-1:0]  FAILSAFE_MS_RST = 16'd1000;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_HOP_OFFSET  = 2'd0,
      REG_DWELL_MS    = 2'd1,
      REG_FAILSAFE_MS = 2'd2,
      REG_BIND_MODE   = 2'd3
   } csr_index_type;

   // Item kinds on the request channel
   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_FRAME = 1'b1
   } item_kind_type;

endpackage

// File: rtl/hop_channel_resync_tracker_unit.sv
// Top level of the receiver-side hop channel resync tracker.
// Depends on hcrt_pkg.
//
// Each request word (a time tick or a received frame) yields exactly one
// response word in the cycle after it is accepted: the channel to listen on,
// whether the step changed it, and the RC data failsafe flag. A new word is
// taken in every cycle; the only limit is the single response register,
// which also stalls the request side while the response side holds off.
// Configuration writes are registered and are meant for idle periods.
module hop_channel_resync_tracker_unit #(
   parameter int CHANNEL_COUNT = hcrt_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [hcrt_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [hcrt_pkg::CHAN_W-1:0]     req_rx_channel,
   input  logic                            req_frame_is_rc_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hcrt_pkg::CHAN_W-1:0]     rsp_channel,
   output logic                            rsp_hopped,
   output logic                            rsp_failsafe,
   // configuration port
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [hcrt_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int CH_W = $clog2(CHANNEL_COUNT);
   localparam logic [CH_W:0] CH_N = (CH_W+1)'(CHANNEL_COUNT);
   localparam int T_W = hcrt_pkg::TIME_W;
   localparam int D_W = hcrt_pkg::DWELL_W;

   // Reduce a 7-bit value modulo the channel count by shifted subtraction
   function automatic logic [CH_W-1:0] chan_mod(input logic [6:0] v);
      logic [13:0] r;
      r = {7'd0, v};
      for (int k = 6; k >= 0; k--) begin
         if (r >= (14'(CHANNEL_COUNT) << k)) begin
            r = r - (14'(CHANNEL_COUNT) << k);
         end
      end
      return r[CH_W-1:0];
   endfunction

   // Configuration registers; dwell multiples are kept ready for the tick path
   logic [CH_W-1:0]  offset_ff, offset_in;
   logic [D_W-1:0]   dwell_ff, dwell_in;
   logic [D_W+1:0]   dwell2_ff, dwell2_in;
   logic [D_W+2:0]   dwell5_ff, dwell5_in;
   logic [D_W+2:0]   dwell6_ff, dwell6_in;
   logic [D_W-1:0]   fs_ms_ff, fs_ms_in;
   logic             bind_ff, bind_in;

   // Tracker state
   logic [CH_W-1:0]               chan_ff, chan_in;
   logic [T_W-1:0]                entry_ff, entry_in;
   logic [hcrt_pkg::MISS_W-1:0]   missed_ff, missed_in;
   logic [T_W-1:0]                last_rc_ff, last_rc_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]               rsp_chan_ff, rsp_chan_in;
   logic                          rsp_hop_ff, rsp_hop_in;
   logic                          rsp_fs_ff, rsp_fs_in;

   // Datapath signals
   logic                          req_acc;
   logic                          is_frame;
   logic                          rc_now;
   logic                          fwd_ok, back_ok;
   logic [hcrt_pkg::MISS_W-1:0]   missed_fwd;
   logic [T_W-1:0]                sum_d1, sum_d5, sum_d6;
   logic [CH_W:0]                 fwd_sum, back_sum;
   logic [CH_W-1:0]               chan_fwd, chan_back, chan_tick, chan_frame;
   logic [CH_W:0]                 back_base;
   logic [T_W-1:0]                fs_last, fs_now;

   // Latch configuration writes and precompute dwell multiples
   always_comb begin
      offset_in = offset_ff;
      dwell_in  = dwell_ff;
      dwell2_in = dwell2_ff;
      dwell5_in = dwell5_ff;
      dwell6_in = dwell6_ff;
      fs_ms_in  = fs_ms_ff;
      bind_in   = bind_ff;
      if (csr_we) begin
         case (hcrt_pkg::csr_index_type'(csr_index))
            hcrt_pkg::REG_HOP_OFFSET: begin
               offset_in = chan_mod({1'b0, csr_wdata[hcrt_pkg::OFFSET_W-1:0]});
            end
            hcrt_pkg::REG_DWELL_MS: begin
               dwell_in  = csr_wdata;
               dwell2_in = {csr_wdata, 1'b0} + (D_W+2)'(0);
               dwell5_in = {csr_wdata, 2'b00} + (D_W+3)'(csr_wdata);
               dwell6_in = {csr_wdata, 2'b00} + (D_W+3)'({csr_wdata, 1'b0});
            end
            hcrt_pkg::REG_FAILSAFE_MS: begin
               fs_ms_in = csr_wdata;
            end
            hcrt_pkg::REG_BIND_MODE: begin
               bind_in = csr_wdata[0];
            end
            default: begin
               bind_in = bind_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= chan_mod({1'b0, hcrt_pkg::HOP_OFFSET_RST});
         dwell_ff  <= hcrt_pkg::DWELL_MS_RST;
         dwell2_ff <= (D_W+2)'({hcrt_pkg::DWELL_MS_RST, 1'b0});
         dwell5_ff <= {hcrt_pkg::DWELL_MS_RST, 2'b00} + (D_W+3)'(hcrt_pkg::DWELL_MS_RST);
         dwell6_ff <= {hcrt_pkg::DWELL_MS_RST, 2'b00}
                      + (D_W+3)'({hcrt_pkg::DWELL_MS_RST, 1'b0});
         fs_ms_ff  <= hcrt_pkg::FAILSAFE_MS_RST;
         bind_ff   <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         dwell_ff  <= dwell_in;
         dwell2_ff <= dwell2_in;
         dwell5_ff <= dwell5_in;
         dwell6_ff <= dwell6_in;
         fs_ms_ff  <= fs_ms_in;
         bind_ff   <= bind_in;
      end
   end

   // Take a word whenever the response register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;
   assign is_frame  = (req_kind == hcrt_pkg::KIND_FRAME);
   assign rc_now    = is_frame && req_frame_is_rc_data;

   // Dwell deadlines, all in wrapping 32-bit time, compared in parallel
   assign sum_d1 = entry_ff + T_W'(dwell_ff);
   assign sum_d5 = entry_ff + T_W'(dwell5_ff);
   assign sum_d6 = entry_ff + T_W'(dwell6_ff);

   // Forward hop while the miss count is below the limit
   assign fwd_ok     = (missed_ff < hcrt_pkg::FWD_MISS_LIMIT) && (sum_d1 < req_now_ms);
   assign missed_fwd = fwd_ok ? missed_ff + 1'b1 : missed_ff;
   assign fwd_sum    = {1'b0, chan_ff} + {1'b0, offset_ff};
   assign chan_fwd   = (fwd_sum >= CH_N) ? CH_W'(fwd_sum - CH_N) : fwd_sum[CH_W-1:0];
   assign chan_tick  = fwd_ok ? chan_fwd : chan_ff;

   // Backward hop once the limit is reached; entry already moved if we hopped forward
   assign back_ok   = (missed_fwd >= hcrt_pkg::FWD_MISS_LIMIT)
                      && ((fwd_ok ? sum_d6 : sum_d5) < req_now_ms);
   assign back_base = CH_N - {1'b0, offset_ff};
   assign back_sum  = {1'b0, chan_tick} + back_base;
   assign chan_back = (back_sum >= CH_N) ? CH_W'(back_sum - CH_N) : back_sum[CH_W-1:0];

   // Resync from a received frame
   assign chan_frame = chan_mod(7'({1'b0, req_rx_channel}) + 7'(offset_ff));

   // Failsafe against the RC time as it stands after this word
   assign fs_last = last_rc_ff + T_W'(fs_ms_ff);
   assign fs_now  = req_now_ms + T_W'(fs_ms_ff);

   // Next state and response
   always_comb begin
      chan_in      = chan_ff;
      entry_in     = entry_ff;
      missed_in    = missed_ff;
      last_rc_in   = last_rc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_fs_in    = rsp_fs_ff;
      if (req_acc) begin
         if (is_frame) begin
            if (!bind_ff) begin
               chan_in   = chan_frame;
               entry_in  = req_now_ms;
               missed_in = '0;
            end
            if (req_frame_is_rc_data) begin
               last_rc_in = req_now_ms;
            end
         end else if (!bind_ff) begin
            missed_in = missed_fwd;
            chan_in   = back_ok ? chan_back : chan_tick;
            case ({fwd_ok, back_ok})
               2'b11:   entry_in = entry_ff + T_W'(dwell2_ff);
               2'b10:   entry_in = sum_d1;
               2'b01:   entry_in = sum_d1;
               default: entry_in = entry_ff;
            endcase
         end
         rsp_valid_in = 1'b1;
         rsp_chan_in  = chan_in;
         rsp_hop_in   = (chan_in != chan_ff);
         rsp_fs_in    = rc_now ? (fs_now < req_now_ms) : (fs_last < req_now_ms);
      end
   end

   // Hold state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '0;
         entry_ff     <= '0;
         missed_ff    <= '0;
         last_rc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chan_ff      <= chan_in;
         entry_ff     <= entry_in;
         missed_ff    <= missed_in;
         last_rc_ff   <= last_rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_chan_ff <= rsp_chan_in;
      rsp_hop_ff  <= rsp_hop_in;
      rsp_fs_ff   <= rsp_fs_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_channel  = hcrt_pkg::CHAN_W'(rsp_chan_ff);
   assign rsp_hopped   = rsp_hop_ff;
   assign rsp_failsafe = rsp_fs_ff;

endmodule

// File: rtl/hcrt_checker.sv
// Port-level checks of the hop channel resync tracker, bound to its top level.
// Depends on hcrt_pkg and hop_channel_resync_tracker_unit_defines.svh.
`include "hop_channel_resync_tracker_unit_defines.svh"

module hcrt_checker #(
   parameter int CHANNEL_COUNT = hcrt_pkg::CHANNEL_COUNT_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hcrt_pkg::CHAN_W-1:0]   rsp_channel,
   input logic                          rsp_hopped,
   input logic                          rsp_failsafe
);

   localparam logic [hcrt_pkg::CHAN_W:0] CH_N = (hcrt_pkg::CHAN_W+1)'(CHANNEL_COUNT);

   // Hold a stalled response word
   `HCRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_channel) && $stable(rsp_hopped) && $stable(rsp_failsafe), "response word changed while stalled")

   // Every accepted request produces a response in the next cycle
   `HCRT_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "no response after accepted request")

   // Reported channel stays inside the hop set
   `HCRT_ASSERT_NOW(a_chan_range, rsp_valid, {1'b0, rsp_channel} < CH_N, "channel out of range")

   // A word without a hop repeats the channel of the word just before it
   `HCRT_ASSERT_NOW(a_no_hop_same, (rsp_valid && rsp_ready) ##1 (rsp_valid && !rsp_hopped), rsp_channel == $past(rsp_channel), "channel changed without hop flag")

endmodule

bind hop_channel_resync_tracker_unit hcrt_checker #(
   .CHANNEL_COUNT (CHANNEL_COUNT)
) u_hcrt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_channel  (rsp_channel),
   .rsp_hopped   (rsp_hopped),
   .rsp_failsafe (rsp_failsafe)
);

// File: verif/tb.sv
// Self-checking testbench for hop_channel_resync_tracker_unit.
// Depends on hcrt_pkg and the tracker RTL; drives words over valid/ready,
// predicts every response (or takes it from the script) and compares it field by field.
module tb;
   import hcrt_pkg::*;

   localparam int CHANNELS    = CHANNEL_COUNT_DEF;
   localparam int BACK_DWELLS = 5;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 105;
   localparam int HOLD_AT     = 400;
   localparam int LONG_HOLD   = 80;
   localparam int DRAIN       = 10;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      item_kind_type         kind;
      logic [TIME_W-1:0]     now;
      logic [CHAN_W-1:0]     rx;
      logic                  rc;
   } hop_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0]     channel;
      logic                  hopped;
      logic                  failsafe;
   } hop_result_type;

   typedef struct packed {
      logic                  is_csr;
      csr_index_type         reg_idx;
      logic [CSR_W-1:0]      reg_val;
      hop_word_type          word;
      logic                  typed;
      hop_result_type        result;
   } hop_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = 1'b0;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic [CHAN_W-1:0]   req_rx_channel = '0;
   logic                req_frame_is_rc_data = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CHAN_W-1:0]   rsp_channel;
   logic                rsp_hopped;
   logic                rsp_failsafe;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // register shadows, at their reset values
   logic [OFFSET_W-1:0] cfg_offset   = HOP_OFFSET_RST;
   logic [DWELL_W-1:0]  cfg_dwell    = DWELL_MS_RST;
   logic [DWELL_W-1:0]  cfg_failsafe = FAILSAFE_MS_RST;
   logic                cfg_bind     = 1'b0;

   // tracker state of the predictor
   int                  trk_chan = 0;
   logic [TIME_W-1:0]   trk_entry = '0;
   logic [MISS_W-1:0]   trk_miss = '0;
   logic [TIME_W-1:0]   trk_last_rc = '0;

   hop_row_type         script_q[$];
   hop_result_type      expected_q[$];
   logic [TIME_W-1:0]   clk_ms = '0;
   int                  tx_gap_max = 16;
   int                  rx_gap_max = 16;
   int                  fail_count = 0;
   int                  rsp_taken = 0;
   int                  cycles = 0;
   int                  n_frames = 0;
   int                  n_ticks = 0;
   int                  n_hops = 0;
   int                  n_backs = 0;
   int                  n_failsafe = 0;
   int                  n_csr = 0;

   hop_channel_resync_tracker_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_now_ms           (req_now_ms),
      .req_rx_channel       (req_rx_channel),
      .req_frame_is_rc_data (req_frame_is_rc_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_channel          (rsp_channel),
      .rsp_hopped           (rsp_hopped),
      .rsp_failsafe         (rsp_failsafe),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the tracker by one word and return the response it owes.
   function automatic hop_result_type track_step(hop_word_type w);
      hop_result_type    r;
      int                prev_chan;
      int                off;
      logic [TIME_W-1:0] fwd_due;
      logic [TIME_W-1:0] back_due;
      logic [TIME_W-1:0] rc_due;
      off = int'(cfg_offset) % CHANNELS;
      prev_chan = trk_chan;
      if (w.kind == KIND_FRAME) begin
         if (!cfg_bind) begin
            trk_chan = (int'(w.rx) + off) % CHANNELS;
            trk_entry = w.now;
            trk_miss = '0;
         end
         if (w.rc) begin
            trk_last_rc = w.now;
         end
      end else if (!cfg_bind) begin
         // forward hop on a missed dwell, then backward resync once lost
         fwd_due = trk_entry + {16'd0, cfg_dwell};
         if (trk_miss < FWD_MISS_LIMIT && fwd_due < w.now) begin
            trk_miss = trk_miss + 3'd1;
            trk_chan = (trk_chan + off) % CHANNELS;
            trk_entry = fwd_due;
         end
         back_due = trk_entry + {16'd0, cfg_dwell} * BACK_DWELLS;
         if (trk_miss >= FWD_MISS_LIMIT && back_due < w.now) begin
            trk_chan = (CHANNELS + trk_chan - off) % CHANNELS;
            trk_entry = trk_entry + {16'd0, cfg_dwell};
            n_backs++;
         end
      end
      rc_due = trk_last_rc + {16'd0, cfg_failsafe};
      r.channel = CHAN_W'(trk_chan);
      r.hopped = (trk_chan != prev_chan);
      r.failsafe = (rc_due < w.now);
      return r;
   endfunction

   function automatic void add_word(item_kind_type k, logic [TIME_W-1:0] t,
                                    logic [CHAN_W-1:0] rx, logic rc, logic typed,
                                    logic [CHAN_W-1:0] ch, logic hp, logic fs);
      hop_row_type row;
      row = '0;
      row.word.kind = k;
      row.word.now = t;
      row.word.rx = rx;
      row.word.rc = rc;
      row.typed = typed;
      row.result.channel = ch;
      row.result.hopped = hp;
      row.result.failsafe = fs;
      script_q.push_back(row);
   endfunction

   function automatic void add_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      hop_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      script_q.push_back(row);
   endfunction

   // Drive one register write; the caller drops the write enable afterward.
   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_HOP_OFFSET:  cfg_offset = val[OFFSET_W-1:0];
         REG_DWELL_MS:    cfg_dwell = val[DWELL_W-1:0];
         REG_FAILSAFE_MS: cfg_failsafe = val[DWELL_W-1:0];
         REG_BIND_MODE:   cfg_bind = val[0];
         default: ;
      endcase
      n_csr++;
   endtask

   // Drop valid and hold until every response is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Offer one word after a random gap and log its expected response.
   task automatic send_word(hop_word_type w, logic typed, hop_result_type typed_res);
      int             gap;
      hop_result_type r;
      gap = int'($urandom_range(0, tx_gap_max));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_now_ms <= w.now;
      req_rx_channel <= w.rx;
      req_frame_is_rc_data <= w.rc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = track_step(w);
      expected_q.push_back(typed ? typed_res : r);
      if (w.kind == KIND_FRAME) begin
         n_frames++;
      end else begin
         n_ticks++;
      end
   endtask

   // Random words: mostly linked or lost stretches, a few noise words.
   task automatic run_phase(int words);
      int        left;
      int        run_len;
      int        mode;
      int        i;
      int        dw;
      int        fsw;
      logic [TIME_W-1:0] step;
      hop_word_type w;
      left = words;
      dw = int'(cfg_dwell);
      fsw = int'(cfg_failsafe);
      while (left > 0) begin
         run_len = int'($urandom_range(4, 30));
         mode = int'($urandom_range(0, 9));
         for (i = 0; i < run_len && left > 0; i++) begin
            w.rx = CHAN_W'($urandom_range(0, 63));
            w.rc = ($urandom_range(0, 3) != 0);
            if (mode == 9) begin
               w.kind = item_kind_type'($urandom_range(0, 1));
               w.now = $urandom;
               w.rc = 1'($urandom_range(0, 1));
            end else begin
               if (mode <= 5 && $urandom_range(0, 2) == 0) begin
                  w.kind = KIND_FRAME;
                  step = $urandom_range(0, dw);
               end else if (mode <= 5) begin
                  w.kind = KIND_TICK;
                  step = $urandom_range(0, dw + dw / 2 + 1);
               end else begin
                  w.kind = KIND_TICK;
                  step = $urandom_range(dw, 3 * dw + 1);
               end
               if ($urandom_range(0, 15) == 0) begin
                  step = step + $urandom_range(0, 2 * fsw + 2);
               end
               clk_ms = clk_ms + step;
               w.now = clk_ms;
            end
            send_word(w, 1'b0, '0);
            left--;
         end
      end
   endtask

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // Response side: random stalls, one long hold-off, check every word.
   initial begin
      int             gap;
      hop_result_type e;
      wait (!reset);
      forever begin
         gap = (rsp_taken == HOLD_AT) ? LONG_HOLD : int'($urandom_range(0, rx_gap_max));
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected, got channel %0d", $time,
                     rsp_channel);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            check_field("channel", int'(e.channel), int'(rsp_channel));
            check_field("hopped", int'(e.hopped), int'(rsp_hopped));
            check_field("failsafe", int'(e.failsafe), int'(rsp_failsafe));
         end
         if (rsp_hopped) begin
            n_hops++;
         end
         if (rsp_failsafe) begin
            n_failsafe++;
         end
         rsp_taken++;
      end
   end

   // Watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout, %0d responses still due", $time, expected_q.size());
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int                p;
      logic [CSR_W-1:0]  v_off;
      logic [CSR_W-1:0]  v_bind;
      logic [OFFSET_W-1:0] off;
      logic [DWELL_W-1:0] dw;
      logic [DWELL_W-1:0] fs;
      logic              bd;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words: reset values, time extremes and wrap, lost link
      add_word(KIND_TICK, 32'd0, 6'd0, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0);
      add_word(KIND_TICK, 32'd21, 6'd0, 1'b0, 1'b1, 6'd1, 1'b1, 1'b0);
      add_word(KIND_TICK, 32'hFFFF_FFFF, 6'h3F, 1'b1, 1'b1, 6'd2, 1'b1, 1'b1);
      add_word(KIND_FRAME, 32'hFFFF_FFFF, 6'h3F, 1'b1, 1'b1, 6'd0, 1'b1, 1'b1);
      add_word(KIND_TICK, 32'd0, 6'd0, 1'b0, 1'b1, 6'd0, 1'b0, 1'b0);
      for (p = 0; p < 8; p++) begin
         add_word(KIND_TICK, TIME_W'(5000 + p), 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      end
      add_word(KIND_FRAME, 32'd6000, 6'd5, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_FRAME, 32'd6010, 6'd20, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_TICK, 32'd6040, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_TICK, 32'd7200, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_FRAME, 32'd7201, 6'd0, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
      // bind mode: hold the channel, still record RC data
      add_csr(REG_BIND_MODE, 16'd1);
      add_word(KIND_FRAME, 32'd8000, 6'd9, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_TICK, 32'd9000000, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      // offset equal to the channel count lands on the same channel
      add_csr(REG_BIND_MODE, 16'd0);
      add_csr(REG_HOP_OFFSET, 16'd16);
      add_word(KIND_FRAME, 32'd9000001, 6'd7, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_TICK, 32'd9000100, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      // zero dwell and zero timeout
      add_csr(REG_DWELL_MS, 16'd0);
      add_csr(REG_FAILSAFE_MS, 16'd0);
      add_word(KIND_TICK, 32'd9000100, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0);
      add_word(KIND_FRAME, 32'd9000200, 6'd3, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0);

      foreach (script_q[i]) begin
         if (script_q[i].is_csr) begin
            wait_idle();
            write_csr(script_q[i].reg_idx, script_q[i].reg_val);
            csr_we <= 1'b0;
         end else begin
            send_word(script_q[i].word, script_q[i].typed, script_q[i].result);
         end
      end

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         clk_ms = $urandom;
         tx_gap_max = 16;
         rx_gap_max = 16;
         case (p)
            0: begin
               off = 6'd63; dw = 16'hFFFF; fs = 16'hFFFF; bd = 1'b0;
            end
            1: begin
               off = 6'd1; dw = 16'd1; fs = 16'd1; bd = 1'b0;
               clk_ms = 32'hFFFF_FF00;
               rx_gap_max = 0;
            end
            2: begin
               off = OFFSET_W'($urandom_range(1, 63)); dw = DWELL_W'($urandom_range(2, 40));
               fs = DWELL_W'($urandom_range(20, 2000)); bd = 1'b0;
               tx_gap_max = 4;
            end
            3: begin
               off = 6'd5; dw = 16'd10; fs = 16'd300; bd = 1'b1;
            end
            4: begin
               off = 6'd16; dw = 16'd0; fs = 16'd0; bd = 1'b0;
               tx_gap_max = 0;
               rx_gap_max = 0;
            end
            5: begin
               off = 6'd0; dw = DWELL_W'($urandom_range(1, 200));
               fs = DWELL_W'($urandom_range(1, 65535)); bd = 1'b0;
            end
            6: begin
               off = OFFSET_W'($urandom_range(1, 63));
               dw = DWELL_W'($urandom_range(1, 65535));
               fs = DWELL_W'($urandom_range(1, 65535)); bd = 1'b0;
               tx_gap_max = 0;
            end
            default: begin
               off = 6'd15; dw = 16'd20; fs = 16'd1000; bd = 1'b0;
               rx_gap_max = 0;
            end
         endcase
         // junk in the unused upper bits must be ignored
         v_off = CSR_W'($urandom);
         v_off[OFFSET_W-1:0] = off;
         v_bind = CSR_W'($urandom);
         v_bind[0] = bd;
         wait_idle();
         write_csr(REG_HOP_OFFSET, v_off);
         write_csr(REG_DWELL_MS, dw);
         write_csr(REG_FAILSAFE_MS, fs);
         write_csr(REG_BIND_MODE, v_bind);
         csr_we <= 1'b0;
         run_phase(PHASE_WORDS);
      end

      wait_idle();
      repeat (DRAIN) @(posedge clock);
      $display("Covered %0d ticks and %0d frames over %0d register writes.",
               n_ticks, n_frames, n_csr);
      $display("Saw %0d hops (%0d backward resyncs) and %0d failsafe responses.",
               n_hops, n_backs, n_failsafe);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
